// ===== sv/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg: shared types and constants for the closest pair distance block
// Default sizes, result field widths, controller states and the
// command/status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths of the ports
    localparam int IN_W   = 16;
    localparam int SQ_W   = 34;
    localparam int ROOT_W = 33;

    // drain wait after the last pair read, so the running minimum is final before the root starts
    localparam int PIPE_DRAIN = 4;

    typedef enum logic [2:0] {
        S_LOAD,
        S_LATCH,
        S_SCAN,
        S_DRAIN,
        S_ROOT,
        S_ROOT_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic wr_en;       // store incoming point
        logic rd_en;       // read point store
        logic rd_latch;    // read returns the anchor point
        logic rd_pair;     // read returns a partner point
        logic clr_best;    // preset running minimum
        logic root_start;  // launch square root on the minimum
        logic emit;        // present the result
        logic found;       // at least two points were stored
        logic ovf;         // points of this set were dropped
    } t_cmd;

    typedef struct packed {
        logic root_busy;
    } t_status;

endpackage

// ===== sv/closest_pair_distance.sv =====
// ----------------------------------------------------------------------------
// closest_pair_distance: smallest distance between any two points of a set
// Loads signed 2-D points and reports the smallest squared distance and
// its square root in unsigned Q.16.
// ----------------------------------------------------------------------------
// Usage
//   Input: a point (i_point_x, i_point_y, i_is_last) is taken at each clock
//   edge with start high and busy low; points beyond MAX_POINTS are
//   dropped and flagged in o_set_overflow.
//   A transaction with i_is_last set closes the set and raises busy.
//   Processing: the store holds one read port, so the pair scan reads
//   each anchor point and then each of its partner points in turn. The
//   pipeline then drains, the root is started and worked out one root bit
//   at a time (33 bits at the default width) until it is seen to finish,
//   and the result is issued.
//   Output: o_valid is high for exactly one cycle with the result fields;
//   the receiver cannot stall, so nothing waits on it. busy drops in the
//   cycle the result appears, and the next set may begin loading then.
//   A set of fewer than two points skips the scan and returns a result
//   after its last transaction, with o_pair_found low and zero distance fields.
//   Reset (i_rst_n low, synchronous) empties the set and cancels any scan;
//   the point store itself is not cleared.
// ----------------------------------------------------------------------------
module closest_pair_distance #(
    parameter int MAX_POINTS = cpd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = cpd_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [cpd_pkg::IN_W-1:0]   i_point_x,
    input  logic [cpd_pkg::IN_W-1:0]   i_point_y,
    input  logic                       i_is_last,
    output logic                       o_valid,
    output logic [cpd_pkg::SQ_W-1:0]   o_min_dist_squared,
    output logic [cpd_pkg::ROOT_W-1:0] o_min_dist_root,
    output logic                       o_pair_found,
    output logic                       o_set_overflow
);

    localparam int IdxW = $clog2(MAX_POINTS);

    cpd_pkg::t_cmd    cmd;
    cpd_pkg::t_status status;
    logic [IdxW-1:0]  wr_addr, rd_addr;

    cpd_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_is_last (i_is_last),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr)
    );

    cpd_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_wr_addr          (wr_addr),
        .i_rd_addr          (rd_addr),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .o_status           (status),
        .o_valid            (o_valid),
        .o_min_dist_squared (o_min_dist_squared),
        .o_min_dist_root    (o_min_dist_root),
        .o_pair_found       (o_pair_found),
        .o_set_overflow     (o_set_overflow)
    );

endmodule

// ===== sv/cpd_ram.sv =====
// ----------------------------------------------------------------------------
// cpd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_w_en,
    input  logic [$clog2(DEPTH)-1:0] i_w_addr,
    input  logic [WIDTH-1:0]         i_w_data,
    input  logic                     i_r_en,
    input  logic [$clog2(DEPTH)-1:0] i_r_addr,
    output logic [WIDTH-1:0]         o_r_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_w_en) begin
            r_mem[i_w_addr] <= i_w_data;
        end
        if (i_r_en) begin
            r_data <= r_mem[i_r_addr];
        end
    end

    assign o_r_data = r_data;

endmodule

// ===== sv/cpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpd_ctrl: sequencer for the closest pair distance block
// Counts loaded points, walks every index pair (i, j > i) over the point
// store, waits for the distance pipeline to drain, runs the root and
// issues the result.
// ----------------------------------------------------------------------------
module cpd_ctrl #(
    parameter int MAX_POINTS = cpd_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_is_last,
    input  cpd_pkg::t_status              i_status,
    output cpd_pkg::t_cmd                 o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_wr_addr,
    output logic [$clog2(MAX_POINTS)-1:0] o_rd_addr
);

    localparam int IdxW = $clog2(MAX_POINTS);
    localparam int CntW = $clog2(MAX_POINTS + 1);

    cpd_pkg::t_state r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    logic [IdxW-1:0] r_i, n_i;
    logic [IdxW-1:0] r_j, n_j;
    logic [2:0]      r_drain, n_drain;
    logic [CntW-1:0] new_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpd_pkg::S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_i       = r_i;
        n_j       = r_j;
        n_drain   = r_drain;
        o_cmd     = '0;
        o_wr_addr = r_cnt[IdxW-1:0];
        o_rd_addr = r_i;
        new_cnt   = r_cnt;
        busy      = (r_state != cpd_pkg::S_LOAD);

        unique case (r_state)
            cpd_pkg::S_LOAD: begin
                if (start) begin
                    if (r_cnt < CntW'(MAX_POINTS)) begin
                        o_cmd.wr_en = 1'b1;
                        new_cnt     = r_cnt + CntW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_cnt = new_cnt;
                    if (i_is_last) begin
                        if (new_cnt >= CntW'(2)) begin
                            o_cmd.clr_best = 1'b1;
                            n_i            = '0;
                            n_state        = cpd_pkg::S_LATCH;
                        end else begin
                            n_state = cpd_pkg::S_EMIT;
                        end
                    end
                end
            end
            cpd_pkg::S_LATCH: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_latch = 1'b1;
                o_rd_addr      = r_i;
                n_j            = r_i + IdxW'(1);
                n_state        = cpd_pkg::S_SCAN;
            end
            cpd_pkg::S_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_pair = 1'b1;
                o_rd_addr     = r_j;
                if (CntW'(r_j) == r_cnt - CntW'(1)) begin
                    if (CntW'(r_i) == r_cnt - CntW'(2)) begin
                        n_drain = 3'(cpd_pkg::PIPE_DRAIN - 1);
                        n_state = cpd_pkg::S_DRAIN;
                    end else begin
                        n_i     = r_i + IdxW'(1);
                        n_state = cpd_pkg::S_LATCH;
                    end
                end else begin
                    n_j = r_j + IdxW'(1);
                end
            end
            cpd_pkg::S_DRAIN: begin
                if (r_drain == 3'd0) begin
                    n_state = cpd_pkg::S_ROOT;
                end else begin
                    n_drain = r_drain - 3'd1;
                end
            end
            cpd_pkg::S_ROOT: begin
                o_cmd.root_start = 1'b1;
                n_state          = cpd_pkg::S_ROOT_WAIT;
            end
            cpd_pkg::S_ROOT_WAIT: begin
                if (!i_status.root_busy) begin
                    n_state = cpd_pkg::S_EMIT;
                end
            end
            cpd_pkg::S_EMIT: begin
                o_cmd.emit  = 1'b1;
                o_cmd.found = (r_cnt >= CntW'(2));
                o_cmd.ovf   = r_ovf;
                n_cnt       = '0;
                n_ovf       = 1'b0;
                n_state     = cpd_pkg::S_LOAD;
            end
            default: begin
                n_state = cpd_pkg::S_LOAD;
            end
        endcase
    end

endmodule

// ===== sv/cpd_datapath.sv =====
// ----------------------------------------------------------------------------
// cpd_datapath: point store, distance pipeline and square root unit
// Pipeline: store read -> abs differences -> squares -> sum -> minimum.
// The root is a restoring digit-by-digit unit, one result bit per cycle.
// ----------------------------------------------------------------------------
module cpd_datapath #(
    parameter int MAX_POINTS = cpd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = cpd_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpd_pkg::t_cmd                 i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    input  logic [cpd_pkg::IN_W-1:0]      i_point_x,
    input  logic [cpd_pkg::IN_W-1:0]      i_point_y,
    output cpd_pkg::t_status              o_status,
    output logic                          o_valid,
    output logic [cpd_pkg::SQ_W-1:0]      o_min_dist_squared,
    output logic [cpd_pkg::ROOT_W-1:0]    o_min_dist_root,
    output logic                          o_pair_found,
    output logic                          o_set_overflow
);

    localparam int CB   = COORD_BITS;
    localparam int SqW  = 2 * CB + 1;          // squared distance width
    localparam int Np   = (SqW + 32 + 1) / 2;  // root bits (radicand is sq * 2^32)
    localparam int RemW = Np + 2;
    localparam int StpW = $clog2(Np + 1);

    // ---- point store ----
    logic signed [CB-1:0] wx, wy;
    logic [2*CB-1:0]      rd_data;

    assign wx = CB'(signed'(i_point_x));
    assign wy = CB'(signed'(i_point_y));

    cpd_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk    (i_clk),
        .i_w_en   (i_cmd.wr_en),
        .i_w_addr (i_wr_addr),
        .i_w_data ({wx, wy}),
        .i_r_en   (i_cmd.rd_en),
        .i_r_addr (i_rd_addr),
        .o_r_data (rd_data)
    );

    // ---- distance pipeline ----
    logic                 r_tag_latch, r_tag_pair, r_v1, r_v2, r_v3;
    logic signed [CB-1:0] r_pi_x, r_pi_y;
    logic signed [CB-1:0] pj_x, pj_y;
    logic signed [CB:0]   dfx, dfy;
    logic [CB-1:0]        ax, ay;
    logic [CB-1:0]        r_ax, r_ay;
    logic [2*CB-1:0]      n_sqx, n_sqy, r_sqx, r_sqy;
    logic [SqW-1:0]       r_sum, r_best;

    assign pj_x = signed'(rd_data[2*CB-1:CB]);
    assign pj_y = signed'(rd_data[CB-1:0]);
    assign dfx  = (CB+1)'(r_pi_x) - (CB+1)'(pj_x);
    assign dfy  = (CB+1)'(r_pi_y) - (CB+1)'(pj_y);
    assign ax   = dfx[CB] ? CB'(-dfx) : CB'(dfx);
    assign ay   = dfy[CB] ? CB'(-dfy) : CB'(dfy);
    assign n_sqx = {{CB{1'b0}}, r_ax} * {{CB{1'b0}}, r_ax};
    assign n_sqy = {{CB{1'b0}}, r_ay} * {{CB{1'b0}}, r_ay};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_latch <= 1'b0;
            r_tag_pair  <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            r_tag_latch <= i_cmd.rd_latch;
            r_tag_pair  <= i_cmd.rd_pair;
            r_v1        <= r_tag_pair;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tag_latch) begin
            r_pi_x <= pj_x;
            r_pi_y <= pj_y;
        end
        r_ax  <= ax;
        r_ay  <= ay;
        r_sqx <= n_sqx;
        r_sqy <= n_sqy;
        r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};
        if (i_cmd.clr_best) begin
            r_best <= '1;
        end else if (r_v3 && (r_sum < r_best)) begin
            r_best <= r_sum;
        end
    end

    // ---- square root, floor(sqrt(best * 2^32)) ----
    logic                r_run;
    logic [StpW-1:0]     r_step;
    logic [2*Np-1:0]     r_rad;
    logic [RemW-1:0]     r_rem;
    logic [Np-1:0]       r_root;
    logic [RemW-1:0]     rem_sh, trial;

    assign rem_sh = {r_rem[RemW-3:0], r_rad[2*Np-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= '0;
        end else if (i_cmd.root_start) begin
            r_run  <= 1'b1;
            r_step <= StpW'(Np);
        end else if (r_run) begin
            r_step <= r_step - StpW'(1);
            if (r_step == StpW'(1)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_start) begin
            r_rad  <= (2*Np)'({r_best, 32'b0});
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_rad <= {r_rad[2*Np-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[Np-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[Np-2:0], 1'b0};
            end
        end
    end

    assign o_status.root_busy = r_run;

    // ---- result registers ----
    logic [SqW+cpd_pkg::SQ_W-1:0]  best_wide;
    logic [Np+cpd_pkg::ROOT_W-1:0] root_wide;
    logic                          r_valid;

    assign best_wide = {{cpd_pkg::SQ_W{1'b0}}, r_best};
    assign root_wide = {{cpd_pkg::ROOT_W{1'b0}}, r_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_min_dist_squared <= i_cmd.found ? best_wide[cpd_pkg::SQ_W-1:0] : '0;
            o_min_dist_root    <= i_cmd.found ? root_wide[cpd_pkg::ROOT_W-1:0] : '0;
            o_pair_found       <= i_cmd.found;
            o_set_overflow     <= i_cmd.ovf;
        end
    end

    assign o_valid = r_valid;

endmodule
